[rtl/lbmcc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lbmcc_pkg: shared types and arithmetic for the D3Q7 cell collision
// Request and result structs, configuration register indexes, and the
// fixed-point round and saturate helpers used by the pipeline stages.
// ----------------------------------------------------------------------------
package lbmcc_pkg;

  // Fixed-point format: two's complement with FRAC_BITS fraction bits
  localparam int FRAC_BITS = 16;
  localparam int ONE_Q     = 1 << FRAC_BITS;
  localparam int HALF_Q    = 1 << (FRAC_BITS - 1);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_C_SQUARED         = 3'd0,
    CFG_REST_WEIGHT       = 3'd1,
    CFG_INV_TAU           = 3'd2,
    CFG_ONE_MINUS_INV_TAU = 3'd3,
    CFG_REFLECT_COEF      = 3'd4
  } cfg_idx_t;

  // One cell on the way in
  typedef struct packed {
    logic signed [31:0] f_rest;
    logic signed [31:0] f_xpos;
    logic signed [31:0] f_xneg;
    logic signed [31:0] f_ypos;
    logic signed [31:0] f_yneg;
    logic signed [31:0] f_zpos;
    logic signed [31:0] f_zneg;
    logic               at_x_face;
    logic               at_y_face;
    logic               at_z_face;
  } cell_in_t;

  // One cell on the way out
  typedef struct packed {
    logic signed [31:0] new_rest;
    logic signed [31:0] new_xpos;
    logic signed [31:0] new_xneg;
    logic signed [31:0] new_ypos;
    logic signed [31:0] new_yneg;
    logic signed [31:0] new_zpos;
    logic signed [31:0] new_zneg;
    logic signed [31:0] density;
  } cell_out_t;

  // Clamp a wide signed value to the 32-bit signed range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // Drop the fraction of a raw product: round half up, then saturate
  function automatic logic signed [31:0] round_sat(input logic signed [63:0] p);
    logic signed [63:0] q;
    q = (p + 64'(HALF_Q)) >>> FRAC_BITS;
    return sat32(q);
  endfunction

endpackage
`default_nettype wire

[rtl/lbm_d3q7_cell_collision.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lbm_d3q7_cell_collision: BGK collision and axis wall reflection, one cell
// Eight-stage pipeline: sums, products, rounding, equilibrium sums, weight
// products, rounding, relaxation products, final add and select.
// ----------------------------------------------------------------------------
// The block takes one cell per clock: a request is taken whenever start is
// high, and busy never rises. The result of each request appears on result
// with done high for one cycle once it has passed the register stages, in
// request order. The pipeline has eight register stages (three multiplier
// stages, each followed by a rounding stage), the first of which is loaded at
// the edge that takes the request. The receiver cannot stall, so results must
// be consumed as they appear.
// Configuration registers may only be written while no request is in flight.
module lbm_d3q7_cell_collision
  import lbmcc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire cell_in_t              req_data,
  output logic                       done,
  output cell_out_t                  result,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic        [16:0] c_squared;
  logic        [16:0] rest_weight;
  logic signed [19:0] inv_tau;
  logic signed [19:0] one_minus_inv_tau;
  logic signed [17:0] reflect_coef;

  // Derived factors: rest factor 1 - 3*c2, moving weight 2*w0, signed c2
  logic signed [19:0] rest_fac;
  logic signed [18:0] w2;
  logic signed [17:0] c2_s;

  logic accept;

  // Stage 1: inputs, density and momenta
  logic               s1_valid;
  logic signed [31:0] s1_rest;
  logic signed [31:0] s1_mv [6];
  logic signed [32:0] s1_j [3];
  logic signed [34:0] s1_rho;
  logic        [2:0]  s1_wall;

  // Stage 2: raw products
  logic               s2_valid;
  logic signed [54:0] s2_p_eq0;
  logic signed [52:0] s2_p_cr;
  logic signed [51:0] s2_p_omt_rest;
  logic signed [51:0] s2_p_omt [6];
  logic signed [49:0] s2_p_refl [6];
  logic signed [32:0] s2_j [3];
  logic        [2:0]  s2_wall;
  logic signed [31:0] s2_dens;

  // Stage 3: rounded products
  logic               s3_valid;
  logic signed [31:0] s3_eq0;
  logic signed [31:0] s3_cr;
  logic signed [31:0] s3_omt_rest;
  logic signed [31:0] s3_omt [6];
  logic signed [31:0] s3_refl [6];
  logic signed [32:0] s3_j [3];
  logic        [2:0]  s3_wall;
  logic signed [31:0] s3_dens;

  // Stage 4: c2*rho +/- J per moving direction
  logic               s4_valid;
  logic signed [31:0] s4_sum [6];
  logic signed [31:0] s4_eq0;
  logic signed [31:0] s4_omt_rest;
  logic signed [31:0] s4_omt [6];
  logic signed [31:0] s4_refl [6];
  logic        [2:0]  s4_wall;
  logic signed [31:0] s4_dens;

  // Stage 5: raw weight products and rest relaxation product
  logic               s5_valid;
  logic signed [50:0] s5_p_eqm [6];
  logic signed [51:0] s5_p_it_rest;
  logic signed [31:0] s5_omt_rest;
  logic signed [31:0] s5_omt [6];
  logic signed [31:0] s5_refl [6];
  logic        [2:0]  s5_wall;
  logic signed [31:0] s5_dens;

  // Stage 6: rounded equilibria
  logic               s6_valid;
  logic signed [31:0] s6_eqm [6];
  logic signed [31:0] s6_it_rest;
  logic signed [31:0] s6_omt_rest;
  logic signed [31:0] s6_omt [6];
  logic signed [31:0] s6_refl [6];
  logic        [2:0]  s6_wall;
  logic signed [31:0] s6_dens;

  // Stage 7: raw relaxation products, finished rest direction
  logic               s7_valid;
  logic signed [51:0] s7_p_it [6];
  logic signed [31:0] s7_new_rest;
  logic signed [31:0] s7_omt [6];
  logic signed [31:0] s7_refl [6];
  logic        [2:0]  s7_wall;
  logic signed [31:0] s7_dens;

  // Stage 8 final values before packing
  logic signed [31:0] fin_mv [6];

  // Pipeline never stalls; configuration is always writable
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign rest_fac = 20'(ONE_Q) - 20'sd3 * $signed({3'b000, c_squared});
  assign w2       = $signed({1'b0, rest_weight, 1'b0});
  assign c2_s     = $signed({1'b0, c_squared});

  // Write configuration registers; ignore indexes beyond the list
  always_ff @(posedge clk) begin
    if (rst) begin
      c_squared         <= 17'd16384;
      rest_weight       <= 17'd16384;
      inv_tau           <= 20'sd131072;
      one_minus_inv_tau <= -20'sd65536;
      reflect_coef      <= 18'sd6554;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_C_SQUARED:         c_squared         <= cfg_data[16:0];
        CFG_REST_WEIGHT:       rest_weight       <= cfg_data[16:0];
        CFG_INV_TAU:           inv_tau           <= $signed(cfg_data[19:0]);
        CFG_ONE_MINUS_INV_TAU: one_minus_inv_tau <= $signed(cfg_data[19:0]);
        CFG_REFLECT_COEF:      reflect_coef      <= $signed(cfg_data[17:0]);
        default: ;
      endcase
    end
  end

  // Advance valid bits along the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
      s7_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      s6_valid <= s5_valid;
      s7_valid <= s6_valid;
      done     <= s7_valid;
    end
  end

  // Stage 1: capture request, sum density and axis momenta
  always_ff @(posedge clk) begin
    s1_rest  <= req_data.f_rest;
    s1_mv[0] <= req_data.f_xpos;
    s1_mv[1] <= req_data.f_xneg;
    s1_mv[2] <= req_data.f_ypos;
    s1_mv[3] <= req_data.f_yneg;
    s1_mv[4] <= req_data.f_zpos;
    s1_mv[5] <= req_data.f_zneg;
    s1_rho   <= 35'(req_data.f_rest) + 35'(req_data.f_xpos) + 35'(req_data.f_xneg)
              + 35'(req_data.f_ypos) + 35'(req_data.f_yneg) + 35'(req_data.f_zpos)
              + 35'(req_data.f_zneg);
    s1_j[0]  <= 33'(req_data.f_xpos) - 33'(req_data.f_xneg);
    s1_j[1]  <= 33'(req_data.f_ypos) - 33'(req_data.f_yneg);
    s1_j[2]  <= 33'(req_data.f_zpos) - 33'(req_data.f_zneg);
    s1_wall  <= {req_data.at_z_face, req_data.at_y_face, req_data.at_x_face};
  end

  // Stage 2: multiply; reflection takes the opposite direction's value
  always_ff @(posedge clk) begin
    s2_p_eq0      <= s1_rho * rest_fac;
    s2_p_cr       <= c2_s * s1_rho;
    s2_p_omt_rest <= one_minus_inv_tau * s1_rest;
    for (int m = 0; m < 6; m++) begin
      s2_p_omt[m]  <= one_minus_inv_tau * s1_mv[m];
      s2_p_refl[m] <= reflect_coef * s1_mv[m ^ 1];
    end
    s2_j    <= s1_j;
    s2_wall <= s1_wall;
    s2_dens <= sat32(64'(s1_rho));
  end

  // Stage 3: round and saturate products
  always_ff @(posedge clk) begin
    s3_eq0      <= round_sat(64'(s2_p_eq0));
    s3_cr       <= round_sat(64'(s2_p_cr));
    s3_omt_rest <= round_sat(64'(s2_p_omt_rest));
    for (int m = 0; m < 6; m++) begin
      s3_omt[m]  <= round_sat(64'(s2_p_omt[m]));
      s3_refl[m] <= round_sat(64'(s2_p_refl[m]));
    end
    s3_j    <= s2_j;
    s3_wall <= s2_wall;
    s3_dens <= s2_dens;
  end

  // Stage 4: add momentum for the positive direction, subtract for negative
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      s4_sum[2*a]     <= sat32(64'(s3_cr) + 64'(s3_j[a]));
      s4_sum[2*a + 1] <= sat32(64'(s3_cr) - 64'(s3_j[a]));
    end
    s4_eq0      <= s3_eq0;
    s4_omt_rest <= s3_omt_rest;
    s4_omt      <= s3_omt;
    s4_refl     <= s3_refl;
    s4_wall     <= s3_wall;
    s4_dens     <= s3_dens;
  end

  // Stage 5: weight the moving sums, start rest relaxation
  always_ff @(posedge clk) begin
    for (int m = 0; m < 6; m++) begin
      s5_p_eqm[m] <= w2 * s4_sum[m];
    end
    s5_p_it_rest <= inv_tau * s4_eq0;
    s5_omt_rest  <= s4_omt_rest;
    s5_omt       <= s4_omt;
    s5_refl      <= s4_refl;
    s5_wall      <= s4_wall;
    s5_dens      <= s4_dens;
  end

  // Stage 6: round equilibria
  always_ff @(posedge clk) begin
    for (int m = 0; m < 6; m++) begin
      s6_eqm[m] <= round_sat(64'(s5_p_eqm[m]));
    end
    s6_it_rest  <= round_sat(64'(s5_p_it_rest));
    s6_omt_rest <= s5_omt_rest;
    s6_omt      <= s5_omt;
    s6_refl     <= s5_refl;
    s6_wall     <= s5_wall;
    s6_dens     <= s5_dens;
  end

  // Stage 7: relaxation products, finish the rest direction
  always_ff @(posedge clk) begin
    for (int m = 0; m < 6; m++) begin
      s7_p_it[m] <= inv_tau * s6_eqm[m];
    end
    s7_new_rest <= sat32(64'(s6_omt_rest) + 64'(s6_it_rest));
    s7_omt      <= s6_omt;
    s7_refl     <= s6_refl;
    s7_wall     <= s6_wall;
    s7_dens     <= s6_dens;
  end

  // Relax each moving direction, or reflect where its axis has a wall
  always_comb begin
    for (int m = 0; m < 6; m++) begin
      if (s7_wall[m >> 1]) begin
        fin_mv[m] = s7_refl[m];
      end else begin
        fin_mv[m] = sat32(64'(s7_omt[m]) + 64'(round_sat(64'(s7_p_it[m]))));
      end
    end
  end

  // Stage 8: result register
  always_ff @(posedge clk) begin
    result.new_rest <= s7_new_rest;
    result.new_xpos <= fin_mv[0];
    result.new_xneg <= fin_mv[1];
    result.new_ypos <= fin_mv[2];
    result.new_yneg <= fin_mv[3];
    result.new_zpos <= fin_mv[4];
    result.new_zneg <= fin_mv[5];
    result.density  <= s7_dens;
  end

  // Every result traces back to an earlier accepted request
  a_done_from_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 8))
    else $error("result without matching request");

  // A captured request always comes out on result with done high
  a_req_reaches_out: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> ##7 done)
    else $error("request lost in pipeline");

  // Density travels unchanged alongside its own cell
  a_density_aligned: assert property (@(posedge clk) disable iff (rst)
    done |-> result.density == $past(s2_dens, 6))
    else $error("density misaligned with its cell");

  // An x wall with zero reflection clears the x pair
  a_x_wall_zero: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_wall[0] && reflect_coef == 18'sd0
      |-> ##7 (result.new_xpos == 32'sd0 && result.new_xneg == 32'sd0))
    else $error("x wall reflection not applied");

endmodule
`default_nettype wire
